FILE: design/rqp_pkg.sv
package rqp_pkg;

  localparam int CharWidth  = 8;
  localparam int BaseWidth  = 27;
  localparam int OutWidth   = 32;
  localparam int AddrWidth  = 3;
  localparam int DataWidth  = 32;

  // Register byte addresses
  localparam logic [AddrWidth-1:0] RegGroupBase = 3'd0;

  // Characters of the query text
  localparam logic [CharWidth-1:0] ChDigit0  = 8'd48;
  localparam logic [CharWidth-1:0] ChDigit9  = 8'd57;
  localparam logic [CharWidth-1:0] ChDot     = 8'h2e;
  localparam logic [CharWidth-1:0] ChColon   = 8'h3a;
  localparam logic [CharWidth-1:0] ChComma   = 8'h2c;
  localparam logic [CharWidth-1:0] ChNewline = 8'h0a;

  // Result kinds
  localparam logic StatusRegion = 1'b0;
  localparam logic StatusError  = 1'b1;

  // Output tdata: region_start, region_end, reverse, group_number, zero pad
  localparam int TdataWidth = 104;

  typedef struct packed {
    logic                 load;
    logic [BaseWidth-1:0] base;
  } cfg_load_t;

endpackage

FILE: design/rqp_cfg.sv
module rqp_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rqp_pkg::AddrWidth-1:0]     paddr,
  input  logic [rqp_pkg::DataWidth-1:0]     pwdata,
  output logic [rqp_pkg::DataWidth-1:0]     prdata,
  output logic                              pready,
  output rqp_pkg::cfg_load_t                cfg
);
  import rqp_pkg::*;

  logic [BaseWidth-1:0] group_base;
  logic                 wr_base;

  assign pready  = 1'b1;
  assign wr_base = psel && penable && pwrite && pready && (paddr == RegGroupBase);

  always_ff @(posedge clk) begin
    if (rst) begin
      group_base <= '0;
    end else if (wr_base) begin
      group_base <= pwdata[BaseWidth-1:0];
    end
  end

  assign prdata   = (paddr == RegGroupBase) ? DataWidth'(group_base) : '0;
  // Parser reloads its group counter on the same write
  assign cfg.load = wr_base;
  assign cfg.base = pwdata[BaseWidth-1:0];

endmodule

FILE: design/rqp_in_stage.sv
module rqp_in_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rqp_pkg::CharWidth-1:0]     s_tdata,   // [7:0] query_char
  output logic                              in_valid,
  output logic [rqp_pkg::CharWidth-1:0]     in_char,
  input  logic                              take
);
  import rqp_pkg::*;

  logic                 valid;
  logic [CharWidth-1:0] char_q;

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      char_q <= s_tdata;
    end
  end

  assign in_valid = valid;
  assign in_char  = char_q;

endmodule

FILE: design/rqp_parse.sv
module rqp_parse #(
  parameter int POS_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rqp_pkg::cfg_load_t                cfg,
  input  logic                              in_valid,
  input  logic [rqp_pkg::CharWidth-1:0]     in_char,
  output logic                              take,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_status,
  output logic [rqp_pkg::OutWidth-1:0]      out_start,
  output logic [rqp_pkg::OutWidth-1:0]      out_end,
  output logic                              out_reverse,
  output logic                              out_closes,
  output logic [rqp_pkg::OutWidth-1:0]      out_group
);
  import rqp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_GAP,
    PH_END,
    PH_BETWEEN,
    PH_FAILED
  } phase_t;

  localparam int MulWidth = POS_WIDTH + 4;

  phase_t                phase, phase_next;
  logic [POS_WIDTH-1:0]  start_accum, start_accum_next;
  logic [POS_WIDTH-1:0]  end_accum, end_accum_next;
  logic [OutWidth-1:0]   group_count;

  logic                  is_digit, is_sep, is_dot, is_colon;
  logic [3:0]            digit;
  logic [POS_WIDTH-1:0]  acc_sel, acc_step;
  logic [MulWidth-1:0]   acc_mul;
  logic                  emit_region, emit_error;

  assign take     = in_valid && (!out_valid || out_ready);
  assign is_digit = (in_char >= ChDigit0) && (in_char <= ChDigit9);
  assign is_colon = (in_char == ChColon);
  assign is_sep   = (in_char == ChComma) || is_colon || (in_char == ChNewline);
  assign is_dot   = (in_char == ChDot);
  assign digit    = in_char[3:0];

  // acc * 10 + digit, clamp at all ones
  assign acc_sel  = (phase == PH_END) ? end_accum : start_accum;
  assign acc_mul  = MulWidth'({acc_sel, 3'b000}) + MulWidth'({acc_sel, 1'b0}) +
                    MulWidth'(digit);
  assign acc_step = (acc_mul[MulWidth-1:POS_WIDTH] != '0) ? '1 : acc_mul[POS_WIDTH-1:0];

  always_comb begin
    phase_next       = phase;
    start_accum_next = start_accum;
    end_accum_next   = end_accum;
    emit_region      = 1'b0;
    emit_error       = 1'b0;
    case (phase)
      PH_IDLE, PH_BETWEEN: begin
        if (is_digit) begin
          start_accum_next = POS_WIDTH'(digit);
          phase_next       = PH_START;
        end
      end
      PH_START: begin
        if (is_sep) begin
          emit_error = 1'b1;
          phase_next = PH_FAILED;
        end else if (is_dot) begin
          phase_next = PH_GAP;
        end else if (is_digit) begin
          start_accum_next = acc_step;
        end
      end
      PH_GAP: begin
        if (is_digit) begin
          end_accum_next = POS_WIDTH'(digit);
          phase_next     = PH_END;
        end
      end
      PH_END: begin
        if (is_dot) begin
          emit_error = 1'b1;
          phase_next = PH_FAILED;
        end else if (is_digit) begin
          end_accum_next = acc_step;
        end else if (is_sep) begin
          emit_region = 1'b1;
          phase_next  = PH_BETWEEN;
        end
      end
      default: begin
        phase_next = PH_FAILED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      start_accum <= '0;
      end_accum   <= '0;
      group_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.load) begin
        group_count <= OutWidth'(cfg.base);
      end else if (take && emit_region && is_colon) begin
        group_count <= group_count + OutWidth'(1);
      end
      if (take) begin
        phase       <= phase_next;
        start_accum <= start_accum_next;
        end_accum   <= end_accum_next;
        out_valid   <= emit_region || emit_error;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register: load only when a result leaves the parser
  always_ff @(posedge clk) begin
    if (take && (emit_region || emit_error)) begin
      out_status  <= emit_error ? StatusError : StatusRegion;
      out_start   <= emit_error ? '0 : OutWidth'(start_accum);
      out_end     <= emit_error ? '0 : OutWidth'(end_accum);
      out_reverse <= emit_region && (end_accum < start_accum);
      out_closes  <= emit_region && is_colon;
      out_group   <= emit_error ? '0 : group_count;
    end
  end

  a_failed_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FAILED |=> phase == PH_FAILED)
    else $error("parser left failed phase");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == StatusError |->
      out_start == '0 && out_end == '0 && !out_reverse && !out_closes && out_group == '0)
    else $error("error result carries region data");

  a_group_hold: assert property (@(posedge clk) disable iff (rst)
    !cfg.load && !(take && emit_region && is_colon) |=> $stable(group_count))
    else $error("group counter moved without colon or config write");

  a_no_result_after_fail: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FAILED && take |=> !out_valid)
    else $error("result produced in failed phase");

endmodule

FILE: design/region_query_parser.sv
// Region query parser.
// Takes one byte of query text (for example 12..40,90..55:7..9) per item on
// the s_* stream and gives one region descriptor when ',', ':' or newline
// closes an end number. A misplaced separator or dot gives one error item
// (m_tuser = 1, other fields zero); after that all input is dropped until
// reset. m_tlast marks a region closed by ':', after which the group number
// advances by one. group_base (APB, address 0) sets the first group number;
// writing it also reloads the group counter. Write it only while idle.
// Path: a byte accepted into the input register is parsed from there, and its
// result is loaded into the result register that drives m_*. Throughput: one
// byte per cycle while no held result waits on m_tready, set by the parser
// step (state update, multiply-by-ten and clamp).
// Reset: parser waits for a first digit, accumulators and group counter are
// zero, both registers are empty.
// When m_tready is low the result holds; one more byte is taken into the
// input register and s_tready then drops until the result is taken.
module region_query_parser #(
  parameter int POS_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rqp_pkg::CharWidth-1:0]     s_tdata,  // [7:0] query_char
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] region_start, [63:32] region_end, [64] reverse,
  // [96:65] group_number, [103:97] zero
  output logic [rqp_pkg::TdataWidth-1:0]    m_tdata,
  output logic                              m_tuser,  // [0] status
  output logic                              m_tlast,  // closes_group
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rqp_pkg::AddrWidth-1:0]     paddr,
  input  logic [rqp_pkg::DataWidth-1:0]     pwdata,
  output logic [rqp_pkg::DataWidth-1:0]     prdata,
  output logic                              pready
);
  import rqp_pkg::*;

  cfg_load_t            cfg;
  logic                 in_valid;
  logic [CharWidth-1:0] in_char;
  logic                 take;
  logic [OutWidth-1:0]  out_start, out_end, out_group;
  logic                 out_reverse;

  rqp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rqp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .in_valid (in_valid),
    .in_char  (in_char),
    .take     (take)
  );

  rqp_parse #(
    .POS_WIDTH (POS_WIDTH)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_char     (in_char),
    .take        (take),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (m_tuser),
    .out_start   (out_start),
    .out_end     (out_end),
    .out_reverse (out_reverse),
    .out_closes  (m_tlast),
    .out_group   (out_group)
  );

  assign m_tdata = {7'b0000000, out_group, out_reverse, out_end, out_start};

endmodule

FILE: verif/rqp_checker.sv
module rqp_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [rqp_pkg::CharWidth-1:0]  s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [rqp_pkg::TdataWidth-1:0] m_tdata,
  input  logic                           m_tuser,
  input  logic                           m_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rqp_pkg::AddrWidth-1:0]  paddr,
  input  logic [rqp_pkg::DataWidth-1:0]  pwdata,
  input  logic                           pready,
  output int                             fails,
  output int                             pending,
  output int                             regions_seen,
  output int                             errors_seen
);
  import rqp_pkg::*;

  typedef enum logic [2:0] {
    PhIdle,
    PhStart,
    PhGap,
    PhEnd,
    PhBetween,
    PhFailed
  } phase_t;

  typedef struct packed {
    logic        status;
    logic [31:0] first_pos;
    logic [31:0] last_pos;
    logic        reverse;
    logic        closes;
    logic [31:0] group;
  } region_t;

  localparam logic [63:0] PosMax = 64'h0000_0000_FFFF_FFFF;

  phase_t      phase;
  logic [63:0] start_acc;
  logic [63:0] end_acc;
  logic [31:0] group_count;
  region_t     region_q[$];

  function automatic logic [63:0] shift_in_digit(logic [63:0] acc, logic [7:0] ch);
    logic [63:0] v;
    v = acc * 64'd10 + (64'(ch) - 64'(ChDigit0));
    return (v > PosMax) ? PosMax : v;
  endfunction

  task automatic parse_char(input logic [7:0] ch);
    logic    is_digit;
    logic    is_sep;
    region_t r;
    is_digit = (ch >= ChDigit0) && (ch <= ChDigit9);
    is_sep   = (ch == ChComma) || (ch == ChColon) || (ch == ChNewline);
    r        = '0;
    r.status = StatusError;
    case (phase)
      PhIdle, PhBetween: begin
        if (is_digit) begin
          start_acc = 64'(ch) - 64'(ChDigit0);
          phase     = PhStart;
        end
      end
      PhStart: begin
        if (is_sep) begin
          region_q.push_back(r);
          phase = PhFailed;
        end else if (ch == ChDot) begin
          phase = PhGap;
        end else if (is_digit) begin
          start_acc = shift_in_digit(start_acc, ch);
        end
      end
      PhGap: begin
        if (is_digit) begin
          end_acc = 64'(ch) - 64'(ChDigit0);
          phase   = PhEnd;
        end
      end
      PhEnd: begin
        if (ch == ChDot) begin
          region_q.push_back(r);
          phase = PhFailed;
        end else if (is_digit) begin
          end_acc = shift_in_digit(end_acc, ch);
        end else if (is_sep) begin
          r.status    = StatusRegion;
          r.first_pos = start_acc[31:0];
          r.last_pos  = end_acc[31:0];
          r.reverse   = end_acc < start_acc;
          r.closes    = ch == ChColon;
          r.group     = group_count;
          region_q.push_back(r);
          // the region keeps the old group number; advance afterwards
          if (ch == ChColon) group_count = group_count + 32'd1;
          phase = PhBetween;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    region_t want;
    if (rst) begin
      phase        = PhIdle;
      start_acc    = '0;
      end_acc      = '0;
      group_count  = '0;
      fails        = 0;
      regions_seen = 0;
      errors_seen  = 0;
      region_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (region_q.size() == 0) begin
          $error("result item with nothing expected: status %0d", m_tuser);
          fails++;
        end else begin
          want = region_q.pop_front();
          check_field("status", 32'(want.status), 32'(m_tuser));
          check_field("region_start", want.first_pos, m_tdata[31:0]);
          check_field("region_end", want.last_pos, m_tdata[63:32]);
          check_field("reverse", 32'(want.reverse), 32'(m_tdata[64]));
          check_field("closes_group", 32'(want.closes), 32'(m_tlast));
          check_field("group_number", want.group, m_tdata[96:65]);
        end
        if (m_tuser == StatusError) errors_seen++;
        else regions_seen++;
      end
      // a write to group_base also reloads the group counter
      if (psel && penable && pwrite && pready && paddr == RegGroupBase) begin
        group_count = 32'(pwdata[BaseWidth-1:0]);
      end
      if (s_tvalid && s_tready) parse_char(s_tdata);
    end
    pending = region_q.size();
  end

endmodule

FILE: verif/tb_region_query_parser.sv
module tb_region_query_parser;
  import rqp_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int PhaseItems  = 280;
  localparam int DrainCycles = 8;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [CharWidth-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TdataWidth-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [AddrWidth-1:0]  paddr    = '0;
  logic [DataWidth-1:0]  pwdata   = '0;
  logic [DataWidth-1:0]  prdata;
  logic                  pready;

  int fails;
  int pending;
  int regions_seen;
  int errors_seen;
  int cycles    = 0;
  int sent      = 0;
  int idle_pct  = 0;
  int stall_pct = 0;

  always #1 clk = ~clk;

  region_query_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  rqp_checker i_region_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fails        (fails),
    .pending      (pending),
    .regions_seen (regions_seen),
    .errors_seen  (errors_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

  task automatic send_byte(input logic [7:0] ch);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic send_text(input string t);
    foreach (t[i]) send_byte(t[i]);
  endtask

  // any non-digit; without punct also no '.' and no separator
  function automatic logic [7:0] filler(input bit punct);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while ((b >= ChDigit0 && b <= ChDigit9) ||
               (!punct && (b == ChDot || b == ChComma || b == ChColon ||
                           b == ChNewline)));
    return b;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 5);
    if (r < 95) return $urandom_range(6, 10);
    return $urandom_range(11, 14);
  endfunction

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 2))
      0:       return ChComma;
      1:       return ChColon;
      default: return ChNewline;
    endcase
  endfunction

  task automatic send_number(input int ndigits, input bit noisy);
    repeat (ndigits) begin
      if (noisy && $urandom_range(0, 9) == 0) send_byte(filler(1'b0));
      send_byte(ChDigit0 + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic send_region();
    int n;
    n = $urandom_range(0, 2);
    repeat (n) send_byte(filler(1'b1));
    send_number(pick_len(), 1'b1);
    send_byte(ChDot);
    // the gap drops every non-digit, dots and separators included
    n = $urandom_range(0, 2);
    repeat (n) send_byte(filler(1'b1));
    send_number(pick_len(), 1'b1);
    send_byte(pick_sep());
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_base(input logic [BaseWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegGroupBase;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [BaseWidth-1:0] bases[4];
    int                   idle_tab[4];
    int                   stall_tab[4];
    int                   target;
    int                   n;
    bases     = '{27'd99999999, 27'd0, 27'd0, 27'd0};
    bases[2]  = 27'($urandom_range(0, 99999999));
    bases[3]  = 27'($urandom_range(0, 99999999));
    idle_tab  = '{0, 73, 0, 16};
    stall_tab = '{0, 0, 73, 16};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      write_base(bases[p]);
      if (p == 0) begin
        send_text("0.0\n");
        // saturated start above the end, closed by colon
        send_text("4294967296.5:");
        send_text("7");
        send_byte(8'hff);
        send_text(".,.2");
        send_byte(8'h80);
        send_text("0:");
      end
      target = sent + PhaseItems;
      while (sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          n = $urandom_range(1, 5);
          repeat (n) send_byte(filler(1'b1));
        end else begin
          send_region();
        end
      end
      wait_idle();
    end

    // one format error is all a run can see: the parser stays failed after it
    idle_pct  = 16;
    stall_pct = 16;
    if ($urandom_range(0, 1) == 0) begin
      send_number(pick_len(), 1'b0);
      send_byte(pick_sep());
    end else begin
      send_number(pick_len(), 1'b0);
      send_byte(ChDot);
      send_number(pick_len(), 1'b0);
      send_byte(ChDot);
    end
    repeat (30) send_byte(8'($urandom_range(0, 255)));
    wait_idle();

    $display("Sent %0d query bytes over four pacing phases and four group bases.", sent);
    $display("Checked %0d region items and %0d format error items.",
             regions_seen, errors_seen);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
